// File: rtl/tarp_pkg.sv
// ----------------------------------------------------------------------------
// tarp_pkg: shared types and constants of the texture rect atlas packer
// Beat layouts of both channels, status and begin codes, and the write port
// format of the layout-index seen table.
// ----------------------------------------------------------------------------
package tarp_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_RECTS_DEF    = 8;
  localparam int ATLAS_WIDTH_DEF  = 128;
  localparam int ATLAS_HEIGHT_DEF = 64;

  // Layout index space: 9-bit index, one seen mark per index
  localparam int INDEX_SLOTS = 512;
  localparam int IDX_W       = $clog2(INDEX_SLOTS);

  // Seen marks are epoch tags; epoch zero is never current
  localparam int EPOCH_W = 8;

  // Rect key: page[4:0], min u, min v, width
  localparam int KEY_W = 30;

  // Begin codes
  localparam logic [1:0] BEGIN_CONT   = 2'd0;
  localparam logic [1:0] BEGIN_HEADER = 2'd1;

  typedef enum logic [1:0] {
    ST_REMAP = 2'd0,
    ST_SKIP  = 2'd1,
    ST_FAIL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  begin_req;
    logic [31:0] command_word;
    logic [7:0]  corner_u0;
    logic [7:0]  corner_u1;
    logic [7:0]  corner_u2;
    logic [7:0]  corner_u3;
    logic [7:0]  corner_v0;
    logic [7:0]  corner_v1;
    logic [7:0]  corner_v2;
    logic [7:0]  corner_v3;
    logic [15:0] page_word;
    logic [15:0] palette_word;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  new_u0;
    logic [7:0]  new_u1;
    logic [7:0]  new_u2;
    logic [7:0]  new_u3;
    logic [7:0]  new_v0;
    logic [7:0]  new_v1;
    logic [7:0]  new_v2;
    logic [7:0]  new_v3;
    logic [15:0] new_page_word;
    logic        best_face;
    logic [3:0]  rects_used;
  } out_beat_t;

  // Seen table write from the pack core
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } seen_wr_t;

endpackage

// File: rtl/tarp_seen_mem.sv
// ----------------------------------------------------------------------------
// tarp_seen_mem: layout-index seen table
// One epoch tag per layout index in a memory. A mark counts as seen when its
// tag equals the current epoch; a header or harvest start bumps the epoch.
// A clearing sweep runs after reset and before the epoch would wrap.
// ----------------------------------------------------------------------------
module tarp_seen_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       clear_i,
  input  logic [tarp_pkg::IDX_W-1:0] addr_i,
  input  logic                       acc_i,
  input  logic                       drained_i,
  input  tarp_pkg::seen_wr_t         wr_i,
  output logic                       ready_o,
  output logic                       busy_o,
  output logic                       seen_o
);

  localparam int EW = tarp_pkg::EPOCH_W;
  localparam int AW = tarp_pkg::IDX_W;

  typedef enum logic {
    SM_CLEAR,
    SM_RUN
  } sm_e;

  sm_e           state_q;
  logic [AW-1:0] ptr_q;
  logic [EW-1:0] epoch_q;
  logic          fwd_q;
  logic [EW-1:0] fwd_ep_q;
  logic [EW-1:0] rd_q;
  logic [EW-1:0] mem [tarp_pkg::INDEX_SLOTS];

  logic          wrap_hold;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic          fwd;

  // a clear at the top epoch must wait for a sweep
  assign wrap_hold = in_valid_i && clear_i && (epoch_q == {EW{1'b1}});
  assign ready_o   = (state_q == SM_RUN) && !wrap_hold;
  assign busy_o    = (state_q == SM_CLEAR);

  always_comb begin
    if (state_q == SM_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = ptr_q;
      mem_wd = '0;
    end else begin
      mem_we = wr_i.en;
      mem_wa = wr_i.addr;
      mem_wd = epoch_q;
    end
  end

  assign fwd    = wr_i.en && (wr_i.addr == addr_i);
  assign seen_o = (fwd_q ? fwd_ep_q : rd_q) == epoch_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (acc_i) begin
      rd_q     <= mem[addr_i];
      fwd_ep_q <= epoch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SM_CLEAR;
      ptr_q   <= '0;
      epoch_q <= EW'(1);
      fwd_q   <= 1'b0;
    end else begin
      case (state_q)
        SM_CLEAR: begin
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == {AW{1'b1}}) begin
            state_q <= SM_RUN;
            epoch_q <= EW'(1);
          end
        end
        SM_RUN: begin
          if (wrap_hold && drained_i) begin
            state_q <= SM_CLEAR;
            ptr_q   <= '0;
          end else if (acc_i) begin
            fwd_q <= fwd;
            if (clear_i) begin
              epoch_q <= epoch_q + EW'(1);
            end
          end
        end
        default: begin
          state_q <= SM_CLEAR;
          ptr_q   <= '0;
        end
      endcase
    end
  end

endmodule

// File: rtl/tarp_pack_core.sv
// ----------------------------------------------------------------------------
// tarp_pack_core: bounding rect, dedupe and shelf packing
// Works one registered command per fire: forms the corner bounding rect,
// matches it against the rect table, shelf-packs new rects and remaps the
// corners. Holds the rect table and all packing state.
// ----------------------------------------------------------------------------
module tarp_pack_core #(
  parameter int MaxRects    = tarp_pkg::MAX_RECTS_DEF,
  parameter int AtlasWidth  = tarp_pkg::ATLAS_WIDTH_DEF,
  parameter int AtlasHeight = tarp_pkg::ATLAS_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tarp_pkg::in_beat_t  item_i,
  input  logic                seen_i,
  input  logic [15:0]         sideload_mask_i,
  output tarp_pkg::out_beat_t result_o,
  output tarp_pkg::seen_wr_t  seen_wr_o
);

  localparam int CntW  = $clog2(MaxRects + 1);
  localparam int SlotW = (MaxRects > 1) ? $clog2(MaxRects) : 1;
  localparam int CalcW = 11;

  typedef struct packed {
    logic [8:0] h;
    logic [7:0] y;
    logic [7:0] x;
  } place_t;

  logic [tarp_pkg::KEY_W-1:0] keys_q [MaxRects];
  place_t                     places_q [MaxRects];

  logic [CntW-1:0] cnt_q, cnt_d, cnt_cur;
  logic [8:0]      sx_q, sx_d, sx_cur;
  logic [9:0]      sy_q, sy_d, sy_cur;
  logic [8:0]      sh_q, sh_d, sh_cur;
  logic [16:0]     best_q, best_d, best_cur;
  logic            failed_q, failed_d, failed_cur;

  logic                       harvest;
  logic [7:0]                 us [4];
  logic [7:0]                 vs [4];
  logic [7:0]                 min_u, max_u, min_v, max_v;
  logic [8:0]                 w, h;
  logic [tarp_pkg::KEY_W-1:0] key;
  logic [tarp_pkg::IDX_W-1:0] idx;
  logic                       skip;
  logic                       found;
  logic [SlotW-1:0]           slot;
  logic                       full;
  logic                       adv;
  logic [8:0]                 nx;
  logic [9:0]                 ny;
  logic [8:0]                 nh;
  logic                       fit_fail;
  logic                       tbl_we;
  logic                       remap;
  place_t                     new_place;
  place_t                     sel_place;
  logic [17:0]                area;

  function automatic logic [3:0] sat_used(input logic [CntW-1:0] c);
    logic [7:0] ce;
    ce = 8'(c);
    return (ce > 8'd15) ? 4'd15 : ce[3:0];
  endfunction

  assign harvest = (item_i.begin_req != tarp_pkg::BEGIN_CONT) &&
                   (item_i.begin_req != tarp_pkg::BEGIN_HEADER);

  assign us[0] = item_i.corner_u0;
  assign us[1] = item_i.corner_u1;
  assign us[2] = item_i.corner_u2;
  assign us[3] = item_i.corner_u3;
  assign vs[0] = item_i.corner_v0;
  assign vs[1] = item_i.corner_v1;
  assign vs[2] = item_i.corner_v2;
  assign vs[3] = item_i.corner_v3;

  // state as seen by this command, after any harvest clear
  assign cnt_cur    = harvest ? '0 : cnt_q;
  assign sx_cur     = harvest ? '0 : sx_q;
  assign sy_cur     = harvest ? '0 : sy_q;
  assign sh_cur     = harvest ? '0 : sh_q;
  assign best_cur   = harvest ? '0 : best_q;
  assign failed_cur = harvest ? 1'b0 : failed_q;

  always_comb begin
    min_u = us[0];
    max_u = us[0];
    min_v = vs[0];
    max_v = vs[0];
    for (int j = 1; j < 4; j++) begin
      if (us[j] < min_u) min_u = us[j];
      if (us[j] > max_u) max_u = us[j];
      if (vs[j] < min_v) min_v = vs[j];
      if (vs[j] > max_v) max_v = vs[j];
    end
  end

  assign w   = {1'b0, max_u} - {1'b0, min_u} + 9'd1;
  assign h   = {1'b0, max_v} - {1'b0, min_v} + 9'd1;
  assign key = {w, min_v, min_u, item_i.page_word[4:0]};
  assign idx = item_i.command_word[tarp_pkg::IDX_W-1:0];

  assign skip = (item_i.command_word[31:16] == 16'd0) ||
                (idx == '0) || seen_i;

  // parallel match over the filled entries
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int k = 0; k < MaxRects; k++) begin
      if (!found && (CntW'(k) < cnt_cur) && (keys_q[k] == key)) begin
        found = 1'b1;
        slot  = SlotW'(k);
      end
    end
  end

  assign full = cnt_cur >= CntW'(MaxRects);

  // close the shelf when the rect does not fit its remainder
  assign adv = (CalcW'(sx_cur) + CalcW'(w)) > CalcW'(AtlasWidth);
  assign nx  = adv ? '0 : sx_cur;
  assign ny  = adv ? (sy_cur + 10'(sh_cur)) : sy_cur;
  assign nh  = adv ? '0 : sh_cur;

  assign fit_fail = (CalcW'(w) > CalcW'(AtlasWidth)) ||
                    ((CalcW'(ny) + CalcW'(h)) > CalcW'(AtlasHeight));

  assign new_place = '{h: h, y: ny[7:0], x: nx[7:0]};
  assign sel_place = found ? places_q[slot] : new_place;
  assign area      = 18'(w) * 18'(sel_place.h);

  always_comb begin
    cnt_d    = cnt_cur;
    sx_d     = sx_cur;
    sy_d     = sy_cur;
    sh_d     = sh_cur;
    best_d   = best_cur;
    failed_d = failed_cur;
    tbl_we   = 1'b0;
    remap    = 1'b0;

    seen_wr_o.en   = 1'b0;
    seen_wr_o.addr = idx;

    result_o            = '0;
    result_o.status     = tarp_pkg::ST_SKIP;
    result_o.rects_used = sat_used(cnt_cur);

    if (failed_cur) begin
      result_o.status = tarp_pkg::ST_FAIL;
    end else if (!skip) begin
      seen_wr_o.en = fire_i;
      if (found) begin
        remap = 1'b1;
      end else if (full) begin
        failed_d        = 1'b1;
        result_o.status = tarp_pkg::ST_FAIL;
      end else begin
        sx_d = nx;
        sy_d = ny;
        sh_d = nh;
        if (fit_fail) begin
          failed_d        = 1'b1;
          result_o.status = tarp_pkg::ST_FAIL;
        end else begin
          tbl_we = 1'b1;
          remap  = 1'b1;
          sx_d   = nx + w;
          sh_d   = (h > nh) ? h : nh;
          cnt_d  = cnt_cur + CntW'(1);
        end
      end
    end

    if (remap) begin
      result_o.status        = tarp_pkg::ST_REMAP;
      result_o.new_u0        = sel_place.x + us[0] - min_u;
      result_o.new_u1        = sel_place.x + us[1] - min_u;
      result_o.new_u2        = sel_place.x + us[2] - min_u;
      result_o.new_u3        = sel_place.x + us[3] - min_u;
      result_o.new_v0        = sel_place.y + vs[0] - min_v;
      result_o.new_v1        = sel_place.y + vs[1] - min_v;
      result_o.new_v2        = sel_place.y + vs[2] - min_v;
      result_o.new_v3        = sel_place.y + vs[3] - min_v;
      result_o.new_page_word = item_i.page_word | sideload_mask_i;
      result_o.rects_used    = sat_used(cnt_d);
      if ((w == sel_place.h) && (area > {1'b0, best_cur})) begin
        best_d             = area[16:0];
        result_o.best_face = 1'b1;
      end
    end
  end

  // append a new rect at the fill point
  always_ff @(posedge clk_i) begin
    if (fire_i && tbl_we) begin
      keys_q[cnt_cur[SlotW-1:0]]   <= key;
      places_q[cnt_cur[SlotW-1:0]] <= new_place;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      sh_q     <= '0;
      best_q   <= '0;
      failed_q <= 1'b0;
    end else if (fire_i) begin
      cnt_q    <= cnt_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      sh_q     <= sh_d;
      best_q   <= best_d;
      failed_q <= failed_d;
    end
  end

endmodule

// File: rtl/texture_rect_atlas_packer.sv
// ----------------------------------------------------------------------------
// texture_rect_atlas_packer: shelf atlas packer with rect dedupe
// Takes texture-layout commands and returns remapped corners and page words.
//
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i carries one command per
//   beat; output channel out_valid_o/out_stall_i/out_data_o returns exactly
//   one result beat per command, in order. A beat moves on a rising edge with
//   valid high and stall low. cfg_we_i writes cfg_wdata_i into the sideload
//   mask; write it only while no command is in flight.
//   A command accepted into the work stage register is worked there and its
//   result beat moves into the result register when that stage advances.
//   Throughput: one command per cycle unless out_stall_i or a sweep stalls it.
//   The layout-index seen table is epoch tagged; a clearing sweep of all
//   512 index slots runs after reset and again when the epoch would wrap
//   (at the 255th header or harvest start after reset, then at every 254th),
//   during which in_stall_o is high (config writes are still taken).
//   When out_stall_i holds, the result register holds its beat, the work
//   stage fills and then in_stall_o rises; nothing is dropped.
//   Reset clears the mask, rect table count, shelf, best area and failure.
// ----------------------------------------------------------------------------
module texture_rect_atlas_packer #(
  parameter int MaxRects    = tarp_pkg::MAX_RECTS_DEF,
  parameter int AtlasWidth  = tarp_pkg::ATLAS_WIDTH_DEF,
  parameter int AtlasHeight = tarp_pkg::ATLAS_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tarp_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tarp_pkg::out_beat_t out_data_o
);

  logic [15:0]         mask_q;
  logic                s1_valid_q;
  tarp_pkg::in_beat_t  s1_data_q;
  logic                out_valid_q;
  tarp_pkg::out_beat_t out_data_q;

  logic                in_acc;
  logic                s1_adv;
  logic                mem_ready;
  logic                mem_busy;
  logic                seen;
  tarp_pkg::seen_wr_t  seen_wr;
  tarp_pkg::out_beat_t core_res;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !mem_ready || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  tarp_seen_mem u_seen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .clear_i    (in_data_i.begin_req != tarp_pkg::BEGIN_CONT),
    .addr_i     (in_data_i.command_word[tarp_pkg::IDX_W-1:0]),
    .acc_i      (in_acc),
    .drained_i  (!s1_valid_q),
    .wr_i       (seen_wr),
    .ready_o    (mem_ready),
    .busy_o     (mem_busy),
    .seen_o     (seen)
  );

  tarp_pack_core #(
    .MaxRects    (MaxRects),
    .AtlasWidth  (AtlasWidth),
    .AtlasHeight (AtlasHeight)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (s1_adv),
    .item_i          (s1_data_q),
    .seen_i          (seen),
    .sideload_mask_i (mask_q),
    .result_o        (core_res),
    .seen_wr_o       (seen_wr)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= core_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // no command enters while the seen table is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> in_stall_o)
    else $error("command accepted during seen table sweep");

  // skipped and failed results carry no page word and no face flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != tarp_pkg::ST_REMAP)
      |-> (out_data_o.best_face == 1'b0) && (out_data_o.new_page_word == 16'd0))
    else $error("non-remap result carries payload");

  // the rect table never reports more entries than it holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (8'(out_data_o.rects_used) <= 8'(MaxRects)))
    else $error("rects_used beyond table depth");
`endif

endmodule

// File: tb/atlas_pack_scoreboard.sv
// ----------------------------------------------------------------------------
// atlas_pack_scoreboard: result checker for the texture rect atlas packer
// Watches the command and result channels and the mask write port. Keeps its
// own copy of the rect table, shelf and seen indexes, predicts one result per
// accepted command and compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
module atlas_pack_scoreboard #(
  parameter int MaxRects    = tarp_pkg::MAX_RECTS_DEF,
  parameter int AtlasWidth  = tarp_pkg::ATLAS_WIDTH_DEF,
  parameter int AtlasHeight = tarp_pkg::ATLAS_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  tarp_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  tarp_pkg::out_beat_t out_data_i,
  output int unsigned         owed_o,
  output int unsigned         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]                    mask_q;
  logic [tarp_pkg::KEY_W-1:0]     packed_keys [MaxRects];
  int                             packed_x [MaxRects];
  int                             packed_y [MaxRects];
  int                             packed_h [MaxRects];
  int                             n_rects;
  int                             shelf_fill;
  int                             shelf_top;
  int                             shelf_tall;
  int                             largest_face;
  bit [tarp_pkg::INDEX_SLOTS-1:0] seen_idx;
  bit                             overflowed;
  tarp_pkg::out_beat_t            remap_queue [$];
  int unsigned                    errs;

  function automatic void start_harvest();
    n_rects      = 0;
    shelf_fill   = 0;
    shelf_top    = 0;
    shelf_tall   = 0;
    largest_face = 0;
    seen_idx     = '0;
    overflowed   = 1'b0;
  endfunction

  function automatic logic [3:0] used_count(int n);
    return (n > 15) ? 4'd15 : 4'(n);
  endfunction

  function automatic tarp_pkg::out_beat_t pack_layout(tarp_pkg::in_beat_t c);
    tarp_pkg::out_beat_t        r;
    int                         us [4];
    int                         vs [4];
    int                         lo_u, hi_u, lo_v, hi_v, w, h, slot, j;
    logic [tarp_pkg::IDX_W-1:0] idx;
    logic [tarp_pkg::KEY_W-1:0] key;
    bit                         hit;
    us[0] = c.corner_u0;
    us[1] = c.corner_u1;
    us[2] = c.corner_u2;
    us[3] = c.corner_u3;
    vs[0] = c.corner_v0;
    vs[1] = c.corner_v1;
    vs[2] = c.corner_v2;
    vs[3] = c.corner_v3;

    // both harvest codes clear everything but the mask
    if (c.begin_req[1]) begin
      start_harvest();
    end else if (c.begin_req == tarp_pkg::BEGIN_HEADER) begin
      seen_idx = '0;
    end

    r = '0;
    r.rects_used = used_count(n_rects);
    if (overflowed) begin
      r.status = tarp_pkg::ST_FAIL;
      return r;
    end

    idx = c.command_word[tarp_pkg::IDX_W-1:0];
    if (c.command_word[31:16] == '0 || idx == '0 || seen_idx[idx]) begin
      r.status = tarp_pkg::ST_SKIP;
      return r;
    end
    seen_idx[idx] = 1'b1;

    lo_u = us[0];
    hi_u = us[0];
    lo_v = vs[0];
    hi_v = vs[0];
    for (j = 1; j < 4; j++) begin
      if (us[j] < lo_u) lo_u = us[j];
      if (us[j] > hi_u) hi_u = us[j];
      if (vs[j] < lo_v) lo_v = vs[j];
      if (vs[j] > hi_v) hi_v = vs[j];
    end
    w   = hi_u - lo_u + 1;
    h   = hi_v - lo_v + 1;
    key = {9'(w), 8'(lo_v), 8'(lo_u), c.page_word[4:0]};

    hit  = 1'b0;
    slot = 0;
    for (j = 0; j < n_rects; j++) begin
      if (!hit && packed_keys[j] == key) begin
        slot = j;
        hit  = 1'b1;
      end
    end

    if (!hit) begin
      if (n_rects >= MaxRects) begin
        overflowed = 1'b1;
        r.status   = tarp_pkg::ST_FAIL;
        return r;
      end
      // open a new shelf first, then check the height
      if (shelf_fill + w > AtlasWidth) begin
        shelf_fill = 0;
        shelf_top  = shelf_top + shelf_tall;
        shelf_tall = 0;
      end
      if (w > AtlasWidth || shelf_top + h > AtlasHeight) begin
        overflowed = 1'b1;
        r.status   = tarp_pkg::ST_FAIL;
        return r;
      end
      slot              = n_rects;
      packed_keys[slot] = key;
      packed_x[slot]    = shelf_fill;
      packed_y[slot]    = shelf_top;
      packed_h[slot]    = h;
      shelf_fill        = shelf_fill + w;
      if (h > shelf_tall) shelf_tall = h;
      n_rects++;
    end

    r.status        = tarp_pkg::ST_REMAP;
    r.new_u0        = 8'(packed_x[slot] + us[0] - lo_u);
    r.new_u1        = 8'(packed_x[slot] + us[1] - lo_u);
    r.new_u2        = 8'(packed_x[slot] + us[2] - lo_u);
    r.new_u3        = 8'(packed_x[slot] + us[3] - lo_u);
    r.new_v0        = 8'(packed_y[slot] + vs[0] - lo_v);
    r.new_v1        = 8'(packed_y[slot] + vs[1] - lo_v);
    r.new_v2        = 8'(packed_y[slot] + vs[2] - lo_v);
    r.new_v3        = 8'(packed_y[slot] + vs[3] - lo_v);
    r.new_page_word = c.page_word | mask_q;
    // height of the stored rect decides the face, not this command's height
    if (w == packed_h[slot] && w * packed_h[slot] > largest_face) begin
      largest_face = w * packed_h[slot];
      r.best_face  = 1'b1;
    end
    r.rects_used = used_count(n_rects);
    return r;
  endfunction

  function automatic int unsigned field_check(string name, longint unsigned want,
                                              longint unsigned got);
    if (want == got) return 0;
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tarp_pkg::out_beat_t want;
    if (!rst_ni) begin
      mask_q = '0;
      start_harvest();
      remap_queue.delete();
      errs = 0;
    end else begin
      if (cfg_we_i) mask_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) remap_queue.push_back(pack_layout(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (remap_queue.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, out_data_i);
          errs++;
        end else begin
          want = remap_queue.pop_front();
          errs += field_check("status", int'(want.status), int'(out_data_i.status));
          errs += field_check("new_u0", want.new_u0, out_data_i.new_u0);
          errs += field_check("new_u1", want.new_u1, out_data_i.new_u1);
          errs += field_check("new_u2", want.new_u2, out_data_i.new_u2);
          errs += field_check("new_u3", want.new_u3, out_data_i.new_u3);
          errs += field_check("new_v0", want.new_v0, out_data_i.new_v0);
          errs += field_check("new_v1", want.new_v1, out_data_i.new_v1);
          errs += field_check("new_v2", want.new_v2, out_data_i.new_v2);
          errs += field_check("new_v3", want.new_v3, out_data_i.new_v3);
          errs += field_check("new_page_word", want.new_page_word,
                              out_data_i.new_page_word);
          errs += field_check("best_face", want.best_face, out_data_i.best_face);
          errs += field_check("rects_used", want.rects_used, out_data_i.rects_used);
        end
      end
    end
    owed_o   <= remap_queue.size();
    errors_o <= errs;
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the texture rect atlas packer
// Drives a short directed list of corner cases, then random harvests built
// from small pools of rects so that dedupe, shelf advance and overflow all
// occur, under random sender bursts and receiver stalls. The scoreboard
// beside the block predicts and checks every result beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BEGIN_HARVEST     = 2'd2;
  localparam logic [1:0] BEGIN_HARVEST_ALT = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [15:0]         cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  tarp_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  tarp_pkg::out_beat_t out_data;
  int unsigned         owed;
  int unsigned         failures;

  int          burst_left = 0;
  bit          gapless    = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_done  = 1'b0;

  texture_rect_atlas_packer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  atlas_pack_scoreboard u_pack_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .owed_o      (owed),
    .errors_o    (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Build a layout command whose corners span exactly the given rect
  function automatic tarp_pkg::in_beat_t make_layout(logic [1:0] beg, logic [8:0] idx,
                                                     int lo_u, int lo_v, int w, int h,
                                                     logic [15:0] page);
    tarp_pkg::in_beat_t b;
    int                 cu [4];
    int                 cv [4];
    int                 a;
    int                 z;
    int                 j;
    for (j = 0; j < 4; j++) begin
      cu[j] = $urandom_range(lo_u + w - 1, lo_u);
      cv[j] = $urandom_range(lo_v + h - 1, lo_v);
    end
    a     = $urandom_range(3, 0);
    z     = (a + $urandom_range(3, 1)) % 4;
    cu[a] = lo_u;
    cu[z] = lo_u + w - 1;
    a     = $urandom_range(3, 0);
    z     = (a + $urandom_range(3, 1)) % 4;
    cv[a] = lo_v;
    cv[z] = lo_v + h - 1;
    b.begin_req    = beg;
    b.command_word = {16'($urandom_range(65535, 1)), 7'($urandom), idx};
    b.corner_u0    = 8'(cu[0]);
    b.corner_u1    = 8'(cu[1]);
    b.corner_u2    = 8'(cu[2]);
    b.corner_u3    = 8'(cu[3]);
    b.corner_v0    = 8'(cv[0]);
    b.corner_v1    = 8'(cv[1]);
    b.corner_v2    = 8'(cv[2]);
    b.corner_v3    = 8'(cv[3]);
    b.page_word    = page;
    b.palette_word = 16'($urandom);
    return b;
  endfunction

  // Offer one beat, often inserting a random gap at a burst boundary unless gapless
  task automatic send_beat(input tarp_pkg::in_beat_t b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      if (!gapless && $urandom_range(3, 0) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_layout(input logic [1:0] beg, input logic [8:0] idx, input int lo_u,
                             input int lo_v, input int w, input int h,
                             input logic [15:0] page);
    send_beat(make_layout(beg, idx, lo_u, lo_v, w, h, page));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  task automatic write_mask(input logic [15:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random harvests: each draws its commands from a small pool of rects so
  // that repeats dedupe; a share of the beats is skip traffic and noise.
  task automatic run_harvests(input int target);
    int                 counted;
    int                 pool_n, n_hdr, n_cmd, hd, k, p, r;
    int                 pu [10];
    int                 pv [10];
    int                 pw [10];
    int                 ph [10];
    logic [4:0]         pg [10];
    logic [1:0]         beg;
    logic [8:0]         idx;
    logic [8:0]         last_idx;
    tarp_pkg::in_beat_t b;
    counted  = 0;
    last_idx = '0;
    while (counted < target) begin
      pool_n = $urandom_range(9, 3);
      for (p = 0; p < pool_n; p++) begin
        r = $urandom_range(99, 0);
        if (r < 85) begin
          pw[p] = $urandom_range(32, 1);
          ph[p] = $urandom_range(20, 1);
        end else if (r < 95) begin
          pw[p] = $urandom_range(128, 1);
          ph[p] = $urandom_range(64, 1);
        end else begin
          pw[p] = $urandom_range(256, 1);
          ph[p] = $urandom_range(256, 1);
        end
        if ($urandom_range(3, 0) == 0) ph[p] = pw[p];
        pu[p] = $urandom_range(256 - pw[p], 0);
        pv[p] = $urandom_range(256 - ph[p], 0);
        pg[p] = 5'($urandom);
      end
      beg   = ($urandom_range(7, 0) == 0) ? BEGIN_HARVEST_ALT : BEGIN_HARVEST;
      n_hdr = $urandom_range(4, 1);
      for (hd = 0; hd < n_hdr; hd++) begin
        if (hd != 0) beg = tarp_pkg::BEGIN_HEADER;
        n_cmd = $urandom_range(8, 2);
        for (k = 0; k < n_cmd; k++) begin
          r = $urandom_range(99, 0);
          if (r < 80) begin
            if (last_idx != '0 && $urandom_range(9, 0) == 0) idx = last_idx;
            else idx = 9'($urandom_range(511, 1));
            last_idx = idx;
            p = $urandom_range(pool_n - 1, 0);
            b = make_layout(beg, idx, pu[p], pv[p], pw[p], ph[p],
                            {11'($urandom), pg[p]});
          end else begin
            b = tarp_pkg::in_beat_t'({$urandom, $urandom, $urandom, $urandom,
                                      2'($urandom)});
            if (r < 88) begin
              b.command_word[31:16] = '0;
              b.begin_req           = beg;
            end else if (r < 94) begin
              b.command_word[8:0] = '0;
              if (b.command_word[31:16] == '0) b.command_word[31] = 1'b1;
              b.begin_req = beg;
            end
          end
          send_beat(b);
          counted++;
          beg = tarp_pkg::BEGIN_CONT;
        end
      end
      if ($urandom_range(9, 0) == 0) wait_drained();
    end
  endtask

  // Receiver: stall patterns in segments, one long hold-off once armed
  initial begin
    int len;
    int pct;
    int j;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        hold_done = 1'b1;
      end
      len = $urandom_range(64, 8);
      case ($urandom_range(3, 0))
        0: begin
          pct = 0;
        end
        1: begin
          pct = 20;
        end
        2: begin
          pct = 50;
        end
        default: begin
          pct = 85;
        end
      endcase
      for (j = 0; j < len; j++) begin
        out_stall <= ($urandom_range(99, 0) < pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    tarp_pkg::in_beat_t b;
    int                 i;
    int                 pass_no;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mask(16'h0000);
    // colour-only, then index zero
    b = make_layout(BEGIN_HARVEST, 9'd5, 0, 0, 1, 1, 16'h0000);
    b.command_word[31:16] = '0;
    send_beat(b);
    send_layout(tarp_pkg::BEGIN_CONT, 9'd0, 0, 0, 1, 1, 16'h0000);
    // first square, then the same index again
    send_layout(tarp_pkg::BEGIN_CONT, 9'd1, 0, 0, 1, 1, 16'h0000);
    send_layout(tarp_pkg::BEGIN_CONT, 9'd1, 0, 0, 1, 1, 16'h0000);
    b = make_layout(tarp_pkg::BEGIN_CONT, 9'h1FF, 255, 255, 1, 1, 16'hFFFF);
    b.command_word = 32'hFFFF_FFFF;
    b.palette_word = 16'hFFFF;
    send_beat(b);
    // new header frees the index; same rect dedupes
    send_layout(tarp_pkg::BEGIN_HEADER, 9'd1, 0, 0, 1, 1, 16'h0000);
    send_layout(tarp_pkg::BEGIN_CONT, 9'd2, 10, 20, 16, 16, 16'h0003);
    send_layout(tarp_pkg::BEGIN_CONT, 9'd3, 40, 40, 8, 8, 16'h0003);
    // full-width rect forces a new shelf
    send_layout(tarp_pkg::BEGIN_CONT, 9'd4, 0, 100, 128, 4, 16'h0010);
    // overwide rect fails; failure sticks through a header
    send_layout(tarp_pkg::BEGIN_CONT, 9'd5, 0, 0, 256, 1, 16'h0000);
    send_layout(tarp_pkg::BEGIN_CONT, 9'd6, 0, 0, 1, 1, 16'h0000);
    send_layout(tarp_pkg::BEGIN_HEADER, 9'd7, 0, 0, 1, 1, 16'h0000);
    // alternate harvest code clears it; fill the height, then overflow it
    send_layout(BEGIN_HARVEST_ALT, 9'd7, 3, 0, 100, 64, 16'h0000);
    send_layout(tarp_pkg::BEGIN_CONT, 9'd8, 0, 0, 100, 1, 16'h0000);
    // one distinct rect more than the table holds
    for (i = 0; i < 9; i++) begin
      send_layout((i == 0) ? BEGIN_HARVEST : tarp_pkg::BEGIN_CONT, 9'(i + 1), i * 12, 0,
                  10, 10, 16'h0000);
    end
    wait_drained();

    for (pass_no = 0; pass_no < 4; pass_no++) begin
      case (pass_no)
        0: begin
          write_mask(16'hFFFF);
        end
        3: begin
          write_mask(16'h8001);
        end
        default: begin
          write_mask(16'($urandom));
        end
      endcase
      gapless = (pass_no == 1);
      if (pass_no == 0) hold_armed = 1'b1;
      run_harvests(190);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
